FILE: rtl/core/brsc_pkg.sv
package brsc_pkg;

    localparam int MAX_DAYS_DEF = 4096;
    localparam int DAY_W        = 13;
    localparam int CNT_W        = 30;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CNT_W-1:0] PRIME = 30'd1000000007;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENTER,
        S_LEAVE,
        S_FINISH,
        S_SUM
    } state_t;

endpackage

FILE: rtl/core/bounded_run_schedule_counter.sv
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  day_count
// out       output     out_valid/out_stall  schedule_count
// cfg       input      cfg_we               cfg_index, cfg_data
//
// a request with n days (clamped to MAX_DAYS) takes an enter step and a leave
// step per day, as the rest-count memory has one read port, then finish and sum
// the memory has no reset and no clearing pass: each entry is written before use
// in_stall is high while a request is being worked on
// the result waits in an output register, so a new request may start meanwhile

module bounded_run_schedule_counter #(
    parameter int MAX_DAYS = brsc_pkg::MAX_DAYS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [brsc_pkg::DAY_W-1:0]           day_count,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [brsc_pkg::CNT_W-1:0]           schedule_count,
    input  logic                                 cfg_we,
    input  logic [brsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [brsc_pkg::DAY_W-1:0]           cfg_data
);

    localparam int AW = $clog2(MAX_DAYS + 1);
    localparam int CW = (AW > brsc_pkg::DAY_W) ? AW : brsc_pkg::DAY_W;
    localparam int DW = brsc_pkg::DAY_W;
    localparam int NW = brsc_pkg::CNT_W;

    brsc_pkg::state_t state_reg, state_next;

    logic [DW-1:0] min_run_reg, max_run_reg;
    logic [DW-1:0] lo_reg, hi_reg;
    logic          live_reg;
    logic [AW-1:0] n_reg, i_reg;
    logic [NW-1:0] win_reg, end_reg, rest_reg;
    logic [NW-1:0] rd_data_reg;
    logic          e_vld_reg, l_vld_reg;
    logic [NW-1:0] out_reg;
    logic          out_valid_reg;

    logic [NW-1:0] mem [0:MAX_DAYS];

    logic          in_fire, out_fire, sum_fire;
    logic [CW-1:0] i_ext, lo_ext, hi_ext, dc_ext;
    logic [CW-1:0] enter_diff, leave_diff;
    logic          enter_ok, leave_ok;
    logic [AW-1:0] n_start, rd_addr;
    logic [DW-1:0] lo_start;
    logic          last_day;

    logic [NW-1:0] op_a, op_b, alu_res;
    logic          op_sub;
    logic [NW:0]   add_sum, sub_wrap;

    assign in_stall       = (state_reg != brsc_pkg::S_IDLE);
    assign in_fire        = in_valid && !in_stall;
    assign out_valid      = out_valid_reg;
    assign schedule_count = out_reg;
    assign out_fire       = out_valid_reg && !out_stall;
    assign sum_fire       = (state_reg == brsc_pkg::S_SUM) && (!out_valid_reg || !out_stall);

    // day indexing for the sliding window
    assign i_ext      = CW'(i_reg);
    assign lo_ext     = CW'(lo_reg);
    assign hi_ext     = CW'(hi_reg);
    assign dc_ext     = CW'(day_count);
    assign enter_diff = i_ext - lo_ext;
    assign leave_diff = i_ext - hi_ext - CW'(1);
    assign enter_ok   = live_reg && (i_ext >= lo_ext);
    assign leave_ok   = live_reg && (i_ext > hi_ext);
    assign last_day   = (i_reg == n_reg);

    assign n_start  = (dc_ext > CW'(MAX_DAYS)) ? AW'(MAX_DAYS) : dc_ext[AW-1:0];
    assign lo_start = (min_run_reg == '0) ? DW'(1) : min_run_reg;

    // shared modular add / subtract unit
    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_sub = 1'b0;
        unique case (state_reg)
            brsc_pkg::S_ENTER, brsc_pkg::S_FINISH:
            begin
                op_a   = win_reg;
                op_b   = l_vld_reg ? rd_data_reg : '0;
                op_sub = 1'b1;
            end
            brsc_pkg::S_LEAVE:
            begin
                op_a = win_reg;
                op_b = e_vld_reg ? rd_data_reg : '0;
            end
            brsc_pkg::S_SUM:
            begin
                op_a = rest_reg;
                op_b = end_reg;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    always_comb
    begin
        add_sum  = {1'b0, op_a} + {1'b0, op_b};
        sub_wrap = {1'b0, op_a} + ({1'b0, brsc_pkg::PRIME} - {1'b0, op_b});
        if (op_sub)
        begin
            alu_res = (op_a >= op_b) ? (op_a - op_b) : sub_wrap[NW-1:0];
        end
        else
        begin
            alu_res = (add_sum >= {1'b0, brsc_pkg::PRIME})
                ? NW'(add_sum - {1'b0, brsc_pkg::PRIME}) : add_sum[NW-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brsc_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (n_start == '0) ? brsc_pkg::S_SUM : brsc_pkg::S_ENTER;
                end
            end
            brsc_pkg::S_ENTER:  state_next = brsc_pkg::S_LEAVE;
            brsc_pkg::S_LEAVE:  state_next = last_day ? brsc_pkg::S_FINISH : brsc_pkg::S_ENTER;
            brsc_pkg::S_FINISH: state_next = brsc_pkg::S_SUM;
            brsc_pkg::S_SUM:
            begin
                if (sum_fire)
                begin
                    state_next = brsc_pkg::S_IDLE;
                end
            end
            default:            state_next = brsc_pkg::S_IDLE;
        endcase
    end

    // memory read address
    always_comb
    begin
        unique case (state_reg)
            brsc_pkg::S_ENTER: rd_addr = enter_diff[AW-1:0];
            brsc_pkg::S_LEAVE: rd_addr = leave_diff[AW-1:0];
            default:           rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= brsc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            min_run_reg   <= DW'(1);
            max_run_reg   <= DW'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (sum_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    brsc_pkg::REG_MIN_RUN: min_run_reg <= cfg_data;
                    brsc_pkg::REG_MAX_RUN: max_run_reg <= cfg_data;
                    default:               max_run_reg <= max_run_reg;
                endcase
            end
        end
    end

    // rest-count memory
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mem[0] <= NW'(1);
        end
        else if (state_reg == brsc_pkg::S_LEAVE)
        begin
            mem[i_reg] <= end_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            n_reg    <= n_start;
            lo_reg   <= lo_start;
            hi_reg   <= max_run_reg;
            live_reg <= (lo_start <= max_run_reg);
            i_reg    <= AW'(1);
            win_reg  <= '0;
            end_reg  <= NW'(1);
            rest_reg <= NW'(1);
        end
        else
        begin
            unique case (state_reg)
                brsc_pkg::S_ENTER:
                begin
                    e_vld_reg <= enter_ok;
                    if (i_reg != AW'(1))
                    begin
                        win_reg  <= alu_res;
                        end_reg  <= alu_res;
                        rest_reg <= end_reg;
                    end
                end
                brsc_pkg::S_LEAVE:
                begin
                    l_vld_reg <= leave_ok;
                    win_reg   <= alu_res;
                    if (!last_day)
                    begin
                        i_reg <= i_reg + AW'(1);
                    end
                end
                brsc_pkg::S_FINISH:
                begin
                    win_reg  <= alu_res;
                    end_reg  <= alu_res;
                    rest_reg <= end_reg;
                end
                brsc_pkg::S_SUM:
                begin
                    if (sum_fire)
                    begin
                        out_reg <= alu_res;
                    end
                end
                default:
                begin
                    win_reg <= win_reg;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_day_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brsc_pkg::S_ENTER || state_reg == brsc_pkg::S_LEAVE)
            |-> (i_reg != '0 && i_reg <= n_reg))
        else $error("day index outside the request");

    a_result_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == brsc_pkg::S_SUM))
        else $error("result loaded outside the final sum step");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg < brsc_pkg::PRIME))
        else $error("result not reduced modulo the prime");

    a_leave_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brsc_pkg::S_LEAVE)
            |=> (state_reg == brsc_pkg::S_ENTER || state_reg == brsc_pkg::S_FINISH))
        else $error("bad step after window leave read");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CLK_PERIOD  = 12;
    localparam int STALL_NONE  = 0;
    localparam int STALL_LIGHT = 1;
    localparam int STALL_HEAVY = 2;
    localparam int DW          = brsc_pkg::DAY_W;

    class schedule_count_checker;
        logic [brsc_pkg::DAY_W-1:0] min_run;
        logic [brsc_pkg::DAY_W-1:0] max_run;
        logic [brsc_pkg::CNT_W-1:0] rest_tab [0:brsc_pkg::MAX_DAYS_DEF];
        logic [brsc_pkg::CNT_W-1:0] expected_counts [$];
        int mismatches;

        function new();
            min_run = 1;
            max_run = 1;
            mismatches = 0;
        endfunction

        function void set_reg(logic [brsc_pkg::CFG_IDX_W-1:0] idx,
                              logic [brsc_pkg::DAY_W-1:0] value);
            if (idx == brsc_pkg::REG_MIN_RUN)
                min_run = value;
            else
                max_run = value;
        endfunction

        function logic [brsc_pkg::CNT_W-1:0] add_prime(logic [brsc_pkg::CNT_W-1:0] a,
                                                        logic [brsc_pkg::CNT_W-1:0] b);
            logic [31:0] s;
            s = {2'b00, a} + {2'b00, b};
            if (s >= {2'b00, brsc_pkg::PRIME})
                s = s - {2'b00, brsc_pkg::PRIME};
            return s[brsc_pkg::CNT_W-1:0];
        endfunction

        function logic [brsc_pkg::CNT_W-1:0] sub_prime(logic [brsc_pkg::CNT_W-1:0] a,
                                                        logic [brsc_pkg::CNT_W-1:0] b);
            logic [31:0] s;
            if (a >= b)
                s = {2'b00, a} - {2'b00, b};
            else
                s = {2'b00, a} + {2'b00, brsc_pkg::PRIME} - {2'b00, b};
            return s[brsc_pkg::CNT_W-1:0];
        endfunction

        // sliding window over the rest counts of the allowed run lengths
        function logic [brsc_pkg::CNT_W-1:0] count_schedules(logic [brsc_pkg::DAY_W-1:0] days);
            int n;
            int lo;
            int hi;
            int enter_day;
            int leave_day;
            logic [brsc_pkg::CNT_W-1:0] window;
            logic [brsc_pkg::CNT_W-1:0] run_end;
            n = (int'(days) > brsc_pkg::MAX_DAYS_DEF) ? brsc_pkg::MAX_DAYS_DEF
                                                       : int'(days);
            lo = (min_run == 0) ? 1 : int'(min_run);
            hi = int'(max_run);
            window = 0;
            run_end = 1;
            rest_tab[0] = 1;
            for (int i = 1; i <= n; i++)
            begin
                if (lo <= hi)
                begin
                    enter_day = i - lo;
                    leave_day = i - hi - 1;
                    if (enter_day >= 0)
                        window = add_prime(window, rest_tab[enter_day]);
                    if (leave_day >= 0)
                        window = sub_prime(window, rest_tab[leave_day]);
                end
                rest_tab[i] = run_end;
                run_end = window;
            end
            return add_prime(rest_tab[n], run_end);
        endfunction

        function void note_request(logic [brsc_pkg::DAY_W-1:0] days);
            expected_counts = {expected_counts, count_schedules(days)};
        endfunction

        function void check_count(logic [brsc_pkg::CNT_W-1:0] got);
            logic [brsc_pkg::CNT_W-1:0] want;
            if (expected_counts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("schedule_count %0d arrived with no request waiting", got);
            end
            else
            begin
                want = expected_counts.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("schedule_count mismatch: expected %0d, actual %0d",
                                 want, got);
                end
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [brsc_pkg::DAY_W-1:0]     day_count;
    logic                           out_valid;
    logic                           out_stall;
    logic [brsc_pkg::CNT_W-1:0]     schedule_count;
    logic                           cfg_we;
    logic [brsc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [brsc_pkg::DAY_W-1:0]     cfg_data;

    schedule_count_checker counts_chk;
    int burst_left;

    bounded_run_schedule_counter #(
        .MAX_DAYS(brsc_pkg::MAX_DAYS_DEF)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .day_count(day_count),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .schedule_count(schedule_count),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(64'd18_000_000);
        $display("** bounded_run_schedule_counter: FAILED **");
        $finish;
    end

    // receiver stall pattern, with a randomly chosen mode held for a random span
    initial
    begin
        int mode;
        int span;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(STALL_NONE, STALL_HEAVY);
            span = $urandom_range(16, 300);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:  out_stall = 1'b0;
                    STALL_LIGHT: out_stall = ($urandom_range(0, 2) == 0);
                    default:     out_stall = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            counts_chk.check_count(schedule_count);
    end

    task automatic send_days(input logic [brsc_pkg::DAY_W-1:0] days);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 8);
        end
        in_valid = 1'b1;
        day_count = days;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        counts_chk.note_request(days);
        burst_left--;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        burst_left = 0;
        while (counts_chk.expected_counts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_runs(input logic [brsc_pkg::DAY_W-1:0] lo_run,
                              input logic [brsc_pkg::DAY_W-1:0] hi_run);
        wait_idle();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = brsc_pkg::REG_MIN_RUN;
        cfg_data = lo_run;
        @(negedge clk);
        cfg_index = brsc_pkg::REG_MAX_RUN;
        cfg_data = hi_run;
        @(negedge clk);
        cfg_we = 1'b0;
        counts_chk.set_reg(brsc_pkg::REG_MIN_RUN, lo_run);
        counts_chk.set_reg(brsc_pkg::REG_MAX_RUN, hi_run);
    endtask

    function automatic logic [brsc_pkg::DAY_W-1:0] pick_days();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 88)
            return DW'($urandom_range(0, 60));
        else if (roll < 96)
            return DW'($urandom_range(61, 700));
        else
            return DW'($urandom);
    endfunction

    initial
    begin
        int roll;
        logic [brsc_pkg::DAY_W-1:0] lo_run;
        logic [brsc_pkg::DAY_W-1:0] hi_run;
        counts_chk = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        day_count = '0;
        cfg_we = 1'b0;
        cfg_index = brsc_pkg::REG_MIN_RUN;
        cfg_data = '0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting: runs of exactly one day
        send_days(13'd0);
        send_days(13'd1);
        send_days(13'd2);
        send_days(13'd3);
        send_days(13'd5);
        send_days(13'd4096);
        send_days(13'd8191);
        send_days(13'd4097);

        apply_runs(13'd2, 13'd3);
        send_days(13'd0);
        send_days(13'd1);
        send_days(13'd2);
        send_days(13'd7);
        send_days(13'd20);

        // zero minimum
        apply_runs(13'd0, 13'd2);
        send_days(13'd1);
        send_days(13'd2);
        send_days(13'd9);

        // empty window
        apply_runs(13'd5, 13'd3);
        send_days(13'd0);
        send_days(13'd1);
        send_days(13'd10);

        apply_runs(13'd1, 13'd4096);
        send_days(13'd4096);
        send_days(13'd100);

        apply_runs(13'd4096, 13'd4096);
        send_days(13'd4095);
        send_days(13'd4096);

        // runs longer than any schedule
        apply_runs(13'd8191, 13'd8191);
        send_days(13'd8191);
        send_days(13'd50);

        apply_runs(13'd0, 13'd8191);
        send_days(13'd33);

        for (int p = 0; p < 10; p++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                lo_run = DW'($urandom_range(1, 6));
                hi_run = lo_run + DW'($urandom_range(0, 8));
            end
            else if (roll < 85)
            begin
                lo_run = DW'($urandom_range(0, 12));
                hi_run = DW'($urandom_range(0, 12));
            end
            else
            begin
                lo_run = DW'($urandom);
                hi_run = DW'($urandom);
            end
            apply_runs(lo_run, hi_run);
            repeat (7) send_days(pick_days());
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (counts_chk.mismatches == 0 && counts_chk.expected_counts.size() == 0)
            $display("** bounded_run_schedule_counter: PASSED **");
        else
            $display("** bounded_run_schedule_counter: FAILED **");
        $finish;
    end

endmodule

FILE: bounded_run_schedule_counter.f
rtl/core/brsc_pkg.sv
rtl/core/bounded_run_schedule_counter.sv
dv/tb.sv
